@@ sv/murmur2_stream_fingerprint_unit_assert.svh @@
// assertion macros used by the rtl (included by mm2sf_ctrl)
`ifndef MURMUR2_STREAM_FINGERPRINT_UNIT_ASSERT_SVH
`define MURMUR2_STREAM_FINGERPRINT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MM2SF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mm2sf assertion failed");

// next-cycle implication
`define MM2SF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mm2sf assertion failed");

`else

`define MM2SF_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MM2SF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ sv/mm2sf_pkg.sv @@
package mm2sf_pkg;

   localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT  = 24;
   localparam logic [31:0] SEED_RESET = 32'h3dd3b51a;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_K1,
      ST_K2,
      ST_H1,
      ST_H2,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_KWORD,
      MUL_KMIX,
      MUL_HASH,
      MUL_TAIL
   } mul_sel_type;

   typedef struct packed {
      logic        take;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        keep_k;
      logic        fold;
      logic        emit;
      logic        restart;
      logic        seed_wr;
   } cmd_type;

   typedef struct packed {
      logic need_fold;
   } stat_type;

endpackage

@@ sv/mm2sf_datapath.sv @@
module mm2sf_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mm2sf_pkg::cmd_type  cmd,
   output mm2sf_pkg::stat_type stat,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_present,
   input  logic [31:0]       csr_data,
   output logic [31:0]       rsp_fingerprint
);
   import mm2sf_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_ff, hash_in;
   logic [23:0] part_ff, part_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] kmix_ff, kmix_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] fp_ff, fp_in;
   logic [31:0] mul_a;
   logic [31:0] k_shx;
   logic [63:0] mul_full;

   assign stat.need_fold = req_byte_present && (count_ff == 2'd3);
   assign k_shx = prod_ff ^ (prod_ff >> MIX_SHIFT);

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_KWORD: mul_a = kmix_ff;
         MUL_KMIX:  mul_a = k_shx;
         MUL_HASH:  mul_a = hash_ff;
         MUL_TAIL:  mul_a = hash_ff ^ {8'd0, part_ff};
         default:   mul_a = hash_ff;
      endcase
   end

   assign mul_full = {32'd0, mul_a} * {32'd0, MIX_MUL};

   always_comb begin
      seed_in  = seed_ff;
      hash_in  = hash_ff;
      part_in  = part_ff;
      count_in = count_ff;
      kmix_in  = kmix_ff;
      prod_in  = prod_ff;
      fp_in    = fp_ff;

      if (cmd.take && req_byte_present) begin
         if (count_ff == 2'd3) begin
            kmix_in  = {part_ff, req_data_byte};
            part_in  = 24'd0;
            count_in = 2'd0;
         end else begin
            part_in  = {part_ff[15:0], req_data_byte};
            count_in = count_ff + 2'd1;
         end
      end
      if (cmd.mul_en) begin
         prod_in = mul_full[31:0];
      end
      if (cmd.keep_k) begin
         kmix_in = prod_ff;
      end
      if (cmd.fold) begin
         hash_in = prod_ff ^ kmix_ff;
      end
      if (cmd.emit) begin
         fp_in = (count_ff != 2'd0) ? prod_ff : hash_ff;
      end
      // new seed also drops the message in progress
      if (cmd.seed_wr) begin
         seed_in  = csr_data;
         hash_in  = csr_data;
         part_in  = 24'd0;
         count_in = 2'd0;
      end else if (cmd.restart) begin
         hash_in  = seed_ff;
         part_in  = 24'd0;
         count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SEED_RESET;
         hash_ff  <= SEED_RESET;
         part_ff  <= 24'd0;
         count_ff <= 2'd0;
      end else begin
         seed_ff  <= seed_in;
         hash_ff  <= hash_in;
         part_ff  <= part_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kmix_ff <= kmix_in;
      prod_ff <= prod_in;
      fp_ff   <= fp_in;
   end

   assign rsp_fingerprint = fp_ff;

endmodule

@@ sv/mm2sf_ctrl.sv @@
module mm2sf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_end_of_message,
   output logic              req_stall,
   input  logic              csr_valid,
   output logic              csr_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  mm2sf_pkg::stat_type stat,
   output mm2sf_pkg::cmd_type  cmd
);
   import mm2sf_pkg::*;
   `include "murmur2_stream_fingerprint_unit_assert.svh"

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;
   logic      slot_free;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign take      = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_HASH;
      cmd.seed_wr = csr_valid && csr_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.take = 1'b1;
               last_in  = req_end_of_message;
               if (stat.need_fold) begin
                  state_in = ST_K1;
               end else if (req_end_of_message) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_K1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KWORD;
            state_in    = ST_K2;
         end
         ST_K2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KMIX;
            state_in    = ST_H1;
         end
         ST_H1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HASH;
            cmd.keep_k  = 1'b1;
            state_in    = ST_H2;
         end
         ST_H2: begin
            cmd.fold = 1'b1;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TAIL;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.emit    = 1'b1;
               cmd.restart = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MM2SF_ASSERT_NEXT(a_k1_to_k2, clock, reset, state_ff == ST_K1, state_ff == ST_K2)
   `MM2SF_ASSERT_NEXT(a_k2_to_h1, clock, reset, state_ff == ST_K2, state_ff == ST_H1)
   `MM2SF_ASSERT_NEXT(a_out_empty, clock, reset, state_ff == ST_OUT && !rsp_valid_ff, state_ff == ST_IDLE && rsp_valid_ff)
   `MM2SF_ASSERT_NEXT(a_plain_byte, clock, reset, take && !req_end_of_message && !stat.need_fold, state_ff == ST_IDLE)

endmodule

@@ sv/murmur2_stream_fingerprint_unit.sv @@
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------------------
// request  | req_valid/req_stall| req_data_byte, req_byte_present, req_end_of_message
// response | rsp_valid/rsp_stall| rsp_fingerprint
// csr      | csr_valid/csr_ready| csr_data (seed_value)
//
// a request that does not complete a word stays in idle; one that completes a word
// steps K1-K2-H1-H2, using the single shared 32x32 multiplier three times per word
// end of message adds FIN (tail multiply), then OUT (load of the response register)
// reset clears control and restores the default seed; no clearing pass
// the response register parts the channels: a held response stalls the unit only
// when the next response is ready to be loaded
module murmur2_stream_fingerprint_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_fingerprint,
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import mm2sf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one request at a time, steps the shared multiplier
   mm2sf_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .stat               (stat),
      .cmd                (cmd)
   );

   // hash state, byte packing, multiplier and response register
   mm2sf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .csr_data         (csr_data),
      .rsp_fingerprint  (rsp_fingerprint)
   );

endmodule
